// File: sv/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types, constants and helpers of the trilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgi_pkg;

  localparam int unsigned NX_DEF   = 32;
  localparam int unsigned NY_DEF   = 32;
  localparam int unsigned NETA_DEF = 32;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned SAMP_W  = 24;
  localparam int unsigned WIDX_W  = 5;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;

  // diff, position and fraction widths
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned POS_W  = DIFF_W + INV_W + 1;
  localparam int unsigned RAW_W  = POS_W - 24;
  localparam int unsigned FRAC_W = POS_W - 8;

  // lerp value, difference and product widths
  localparam int unsigned LV_W = 30;
  localparam int unsigned LD_W = LV_W + 1;
  localparam int unsigned LP_W = FRAC_W + LD_W;
  localparam int unsigned LS_W = LP_W - 16 + 1;

  localparam logic signed [LV_W-1:0] LIM_HI = LV_W'(1 << 28);
  localparam logic signed [LV_W-1:0] LIM_LO = -LV_W'(1 << 28);
  localparam logic [SAMP_W-1:0] TOP_VALUE = '1;

  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST   = -16'sd3840;
  localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST   = -16'sd3840;
  localparam logic signed [COORD_W-1:0] ETA_ORIGIN_RST = -16'sd2560;
  localparam logic [INV_W-1:0] INV_STEP_RST = 24'd65536;

  typedef enum logic [CIDX_W-1:0] {
    CFG_X_ORIGIN     = 3'd0,
    CFG_Y_ORIGIN     = 3'd1,
    CFG_ETA_ORIGIN   = 3'd2,
    CFG_X_INV_STEP   = 3'd3,
    CFG_Y_INV_STEP   = 3'd4,
    CFG_ETA_INV_STEP = 3'd5
  } cfg_idx_t;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [WIDX_W-1:0] ix;
    logic [WIDX_W-1:0] iy;
    logic [WIDX_W-1:0] ie;
    logic [SAMP_W-1:0] val;
  } wr_t;

  // add the shifted product, saturate to +-2^28
  function automatic logic signed [LV_W-1:0] lerp_finish(
    input logic signed [LV_W-1:0] a,
    input logic signed [LP_W-1:0] m
  );
    logic signed [LS_W-1:0] s;
    logic signed [LP_W-1:0] sh;
    sh = m >>> 16;
    s  = LS_W'(a) + LS_W'(sh);
    if (s > LS_W'(LIM_HI)) begin
      return LIM_HI;
    end else if (s < LS_W'(LIM_LO)) begin
      return LIM_LO;
    end else begin
      return s[LV_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/trilinear_grid_interpolator_unit.sv
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_unit
// Eight-bank sample grid with a pipelined trilinear blend of corner samples.
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  command   action, *_coord, write_*                       start & !busy
//  result    density, saturated                             done (one cycle)
//  config    cfg_we, cfg_index, cfg_data                    cfg_we
//
//  One word enters per cycle; busy stays low. A query's result word passes
//  13 register stages (four for axis locate, address, bank read, two per lerp
//  level along eta, y and x, output clamp).
//  A write word lands in its bank at the bank-read stage, in order with queries.
//  Reset clears the pipeline valid bits and done and loads the configuration
//  registers with reset values; grid contents stay undefined until written.
//  The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_grid_interpolator_unit #(
  parameter int unsigned NX   = tgi_pkg::NX_DEF,
  parameter int unsigned NY   = tgi_pkg::NY_DEF,
  parameter int unsigned NETA = tgi_pkg::NETA_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                action,
  input  wire logic signed [tgi_pkg::COORD_W-1:0]  x_coord,
  input  wire logic signed [tgi_pkg::COORD_W-1:0]  y_coord,
  input  wire logic signed [tgi_pkg::COORD_W-1:0]  eta_coord,
  input  wire logic [tgi_pkg::WIDX_W-1:0]          write_ix,
  input  wire logic [tgi_pkg::WIDX_W-1:0]          write_iy,
  input  wire logic [tgi_pkg::WIDX_W-1:0]          write_ieta,
  input  wire logic [tgi_pkg::SAMP_W-1:0]          write_value,
  output logic                                     done,
  output logic [tgi_pkg::SAMP_W-1:0]               density,
  output logic                                     saturated,
  input  wire logic                                cfg_we,
  input  wire logic [tgi_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [tgi_pkg::CFG_W-1:0]           cfg_data
);

  localparam int unsigned NMAX = (NX > NY) ? ((NX > NETA) ? NX : NETA)
                                           : ((NY > NETA) ? NY : NETA);
  localparam int unsigned IW   = $clog2(NMAX);
  localparam int unsigned HX   = (NX + 1) / 2;
  localparam int unsigned HY   = (NY + 1) / 2;
  localparam int unsigned HE   = (NETA + 1) / 2;
  localparam int unsigned BANK_DEPTH = HX * HY * HE;
  localparam int unsigned AW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned NSZ [3] = '{NX, NY, NETA};
  localparam int unsigned STR [3] = '{HY * HE, HE, 1};
  localparam int unsigned LAST = 12;

  localparam int unsigned CW = tgi_pkg::COORD_W;
  localparam int unsigned FW = tgi_pkg::FRAC_W;
  localparam int unsigned VW = tgi_pkg::LV_W;
  localparam int unsigned PW = tgi_pkg::LP_W;

  // configuration
  logic signed [CW-1:0]              origin [3];
  logic [tgi_pkg::INV_W-1:0]         inv    [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= tgi_pkg::X_ORIGIN_RST;
      origin[1] <= tgi_pkg::Y_ORIGIN_RST;
      origin[2] <= tgi_pkg::ETA_ORIGIN_RST;
      inv[0]    <= tgi_pkg::INV_STEP_RST;
      inv[1]    <= tgi_pkg::INV_STEP_RST;
      inv[2]    <= tgi_pkg::INV_STEP_RST;
    end else if (cfg_we) begin
      unique case (tgi_pkg::cfg_idx_t'(cfg_index))
        tgi_pkg::CFG_X_ORIGIN:     origin[0] <= cfg_data[CW-1:0];
        tgi_pkg::CFG_Y_ORIGIN:     origin[1] <= cfg_data[CW-1:0];
        tgi_pkg::CFG_ETA_ORIGIN:   origin[2] <= cfg_data[CW-1:0];
        tgi_pkg::CFG_X_INV_STEP:   inv[0]    <= cfg_data;
        tgi_pkg::CFG_Y_INV_STEP:   inv[1]    <= cfg_data;
        tgi_pkg::CFG_ETA_INV_STEP: inv[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid and query flags travel with each stage
  logic [LAST:0] vld;
  logic [LAST:0] qry;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      qry <= '0;
    end else begin
      vld <= {vld[LAST-1:0], start & ~busy};
      qry <= {qry[LAST-1:0], action == tgi_pkg::ACT_QUERY};
    end
  end

  // write words ride along to the bank stage
  tgi_pkg::wr_t wr [5];

  always_ff @(posedge clk) begin
    wr[0] <= '{ix: write_ix, iy: write_iy, ie: write_ieta, val: write_value};
    for (int s = 1; s < 5; s++) begin
      wr[s] <= wr[s-1];
    end
  end

  // stage 0..3: locate each axis
  logic signed [CW-1:0]             crd  [3];
  logic signed [tgi_pkg::DIFF_W-1:0] diff [3];
  logic signed [tgi_pkg::POS_W-1:0]  pos  [3];
  logic [IW-1:0]                     idx3 [3];
  logic signed [FW-1:0]              frac3 [3];
  logic [IW-1:0]                     idx_c [3];
  logic signed [FW-1:0]              frac_c [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [tgi_pkg::RAW_W-1:0] raw;
      logic signed [tgi_pkg::POS_W-1:0] rem;
      raw = tgi_pkg::RAW_W'(pos[a] >>> 24);
      if (raw < 0) begin
        idx_c[a] = '0;
      end else if (raw > tgi_pkg::RAW_W'(NSZ[a] - 2)) begin
        idx_c[a] = IW'(NSZ[a] - 2);
      end else begin
        idx_c[a] = raw[IW-1:0];
      end
      rem = pos[a] - (tgi_pkg::POS_W'(idx_c[a]) << 24);
      frac_c[a] = FW'(rem >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    crd[0] <= x_coord;
    crd[1] <= y_coord;
    crd[2] <= eta_coord;
    for (int a = 0; a < 3; a++) begin
      diff[a]  <= tgi_pkg::DIFF_W'(crd[a]) - tgi_pkg::DIFF_W'(origin[a]);
      pos[a]   <= tgi_pkg::POS_W'(diff[a]) *
                  tgi_pkg::POS_W'($signed({1'b0, inv[a]}));
      idx3[a]  <= idx_c[a];
      frac3[a] <= frac_c[a];
    end
  end

  // stage 4: bank addresses
  logic [AW-1:0]        term  [3][2];
  logic [AW-1:0]        raddr [8];
  logic [AW-1:0]        waddr;
  logic [2:0]           wbank;
  logic                 wok;
  logic [2:0]           par4, par5;
  logic signed [FW-1:0] frac4 [3];
  logic signed [FW-1:0] frac5 [3];
  logic signed [FW-1:0] frac6 [3];
  logic signed [FW-1:0] frac7 [2];
  logic signed [FW-1:0] frac8 [2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int p = 0; p < 2; p++) begin
        logic [IW-1:0] c;
        c = (idx3[a][0] == p[0]) ? idx3[a] : idx3[a] + 1'b1;
        term[a][p] = AW'(c >> 1) * AW'(STR[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      raddr[b] <= term[0][b[2]] + term[1][b[1]] + term[2][b[0]];
    end
    wbank <= {wr[3].ix[0], wr[3].iy[0], wr[3].ie[0]};
    waddr <= AW'(wr[3].ix >> 1) * AW'(STR[0]) + AW'(wr[3].iy >> 1) * AW'(STR[1])
           + AW'(wr[3].ie >> 1);
    wok   <= (int'(wr[3].ix) < NX) && (int'(wr[3].iy) < NY) && (int'(wr[3].ie) < NETA);
    par4  <= {idx3[0][0], idx3[1][0], idx3[2][0]};
    frac4 <= frac3;
  end

  // stage 5: eight single-port banks, one access per cycle each
  logic [tgi_pkg::SAMP_W-1:0] rd [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [tgi_pkg::SAMP_W-1:0] mem [BANK_DEPTH];
    logic                       we;

    assign we = vld[4] & ~qry[4] & wok & (wbank == 3'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wr[4].val;
      end else begin
        rd[b] <= mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    par5  <= par4;
    frac5 <= frac4;
  end

  // stages 6..11: lerp along eta, then y, then x
  logic signed [VW-1:0] ea [4];
  logic signed [PW-1:0] em [4];
  logic signed [VW-1:0] ev [4];
  logic signed [VW-1:0] ya [2];
  logic signed [PW-1:0] ym [2];
  logic signed [VW-1:0] yv [2];
  logic signed [VW-1:0] xa;
  logic signed [PW-1:0] xm;
  logic signed [VW-1:0] xv;
  logic signed [VW-1:0] c0 [4];
  logic signed [VW-1:0] c1 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [2:0] b0;
      logic [2:0] b1;
      b0 = {par5[2] ^ k[1], par5[1] ^ k[0], par5[0]};
      b1 = {par5[2] ^ k[1], par5[1] ^ k[0], ~par5[0]};
      c0[k] = VW'(rd[b0]);
      c1[k] = VW'(rd[b1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ea[k] <= c0[k];
      em[k] <= PW'(frac5[2]) * PW'(tgi_pkg::LD_W'(c1[k]) - tgi_pkg::LD_W'(c0[k]));
      ev[k] <= tgi_pkg::lerp_finish(ea[k], em[k]);
    end
    frac6    <= frac5;
    frac7[0] <= frac6[0];
    frac7[1] <= frac6[1];
    for (int j = 0; j < 2; j++) begin
      ya[j] <= ev[2*j];
      ym[j] <= PW'(frac7[1]) *
               PW'(tgi_pkg::LD_W'(ev[2*j+1]) - tgi_pkg::LD_W'(ev[2*j]));
      yv[j] <= tgi_pkg::lerp_finish(ya[j], ym[j]);
    end
    frac8[0] <= frac7[0];
    frac8[1] <= frac8[0];
    xa     <= yv[0];
    xm     <= PW'(frac8[1]) * PW'(tgi_pkg::LD_W'(yv[1]) - tgi_pkg::LD_W'(yv[0]));
    xv     <= tgi_pkg::lerp_finish(xa, xm);
  end

  // stage 12: clamp and present the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST-1] & qry[LAST-1];
    end
    if (xv < 0) begin
      density   <= '0;
      saturated <= 1'b0;
    end else if (xv > VW'(tgi_pkg::TOP_VALUE)) begin
      density   <= tgi_pkg::TOP_VALUE;
      saturated <= 1'b1;
    end else begin
      density   <= xv[tgi_pkg::SAMP_W-1:0];
      saturated <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/tgi_checker.sv
// ----------------------------------------------------------------------------
// tgi_checker
// Port-level checks of the trilinear grid interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          action,
  input wire logic                          done,
  input wire logic [tgi_pkg::SAMP_W-1:0]    density,
  input wire logic                          saturated
);

  localparam int unsigned LAT = 13;

  // a result word only follows an accepted query, a fixed latency earlier
  a_done_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && action == tgi_pkg::ACT_QUERY, LAT))
    else $error("result word without matching query");

  // the saturation flag comes only with the top value
  a_sat_top: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> density == tgi_pkg::TOP_VALUE)
    else $error("saturated flag with non-top density");

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result word right after reset");

  // the pipeline never refuses a command word
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

endmodule

bind trilinear_grid_interpolator_unit tgi_checker u_tgi_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .action    (action),
  .done      (done),
  .density   (density),
  .saturated (saturated)
);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the trilinear grid interpolator unit.
// A few grid planes per axis are filled first, and every query is steered onto
// cells whose eight corners are all set. The test then runs several register
// settings, extremes among them. Each setting has directed and random
// queries, with random sample rewrites mixed in. Every query is predicted in
// 64-bit fixed point, and each result is checked in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int LIMIT = 2000000;
  localparam int DRAIN = 20;

  typedef struct {
    logic                               act;
    logic signed [tgi_pkg::COORD_W-1:0] x;
    logic signed [tgi_pkg::COORD_W-1:0] y;
    logic signed [tgi_pkg::COORD_W-1:0] e;
    logic [tgi_pkg::WIDX_W-1:0]         wx;
    logic [tgi_pkg::WIDX_W-1:0]         wy;
    logic [tgi_pkg::WIDX_W-1:0]         we;
    logic [tgi_pkg::SAMP_W-1:0]         val;
  } word_t;

  class density_scoreboard;
    logic [tgi_pkg::SAMP_W-1:0] grid [32768];
    logic signed [tgi_pkg::COORD_W-1:0] org [3];
    logic [tgi_pkg::INV_W-1:0] inv [3];
    logic [tgi_pkg::SAMP_W-1:0] exp_density [$];
    logic exp_sat [$];
    int mismatches;

    function void set_reg(tgi_pkg::cfg_idx_t idx, logic [tgi_pkg::CFG_W-1:0] data);
      case (idx)
        tgi_pkg::CFG_X_ORIGIN:     org[0] = data[tgi_pkg::COORD_W-1:0];
        tgi_pkg::CFG_Y_ORIGIN:     org[1] = data[tgi_pkg::COORD_W-1:0];
        tgi_pkg::CFG_ETA_ORIGIN:   org[2] = data[tgi_pkg::COORD_W-1:0];
        tgi_pkg::CFG_X_INV_STEP:   inv[0] = data;
        tgi_pkg::CFG_Y_INV_STEP:   inv[1] = data;
        tgi_pkg::CFG_ETA_INV_STEP: inv[2] = data;
        default: ;
      endcase
    endfunction

    function void reset_regs();
      org[0] = tgi_pkg::X_ORIGIN_RST;
      org[1] = tgi_pkg::Y_ORIGIN_RST;
      org[2] = tgi_pkg::ETA_ORIGIN_RST;
      for (int i = 0; i < 3; i++) inv[i] = tgi_pkg::INV_STEP_RST;
    endfunction

    function void locate(logic signed [tgi_pkg::COORD_W-1:0] c, int axis,
                         output int idx, output longint frac);
      longint p;
      longint i;
      p = (longint'(c) - longint'(org[axis])) * longint'({40'd0, inv[axis]});
      i = p >>> 24;
      if (i < 0) i = 0;
      if (i > 30) i = 30;
      idx = int'(i);
      frac = (p - (i <<< 24)) >>> 8;
    endfunction

    // cells whose corner planes are filled: 0, 14, 15 and 30
    function bit cell_ok(logic signed [tgi_pkg::COORD_W-1:0] c, int axis);
      int idx;
      longint f;
      locate(c, axis, idx, f);
      return (idx == 0) || (idx == 14) || (idx == 15) || (idx == 30);
    endfunction

    function longint blend(longint a, longint b, longint f);
      longint v;
      v = a + ((f * (b - a)) >>> 16);
      if (v > (64'sd1 <<< 28)) v = 64'sd1 <<< 28;
      if (v < -(64'sd1 <<< 28)) v = -(64'sd1 <<< 28);
      return v;
    endfunction

    function longint at(int x, int y, int e);
      return longint'({40'd0, grid[(x * 32 + y) * 32 + e]});
    endfunction

    function void note(word_t w);
      int ix, iy, ie;
      longint fx, fy, fe, v;
      longint ay [2];
      longint ae [2];
      if (w.act == tgi_pkg::ACT_WRITE) begin
        grid[(int'(w.wx) * 32 + int'(w.wy)) * 32 + int'(w.we)] = w.val;
        return;
      end
      locate(w.x, 0, ix, fx);
      locate(w.y, 1, iy, fy);
      locate(w.e, 2, ie, fe);
      for (int jx = 0; jx < 2; jx++) begin
        for (int jy = 0; jy < 2; jy++)
          ae[jy] = blend(at(ix + jx, iy + jy, ie), at(ix + jx, iy + jy, ie + 1), fe);
        ay[jx] = blend(ae[0], ae[1], fy);
      end
      v = blend(ay[0], ay[1], fx);
      if (v < 0) begin
        exp_density.push_back('0);
        exp_sat.push_back(1'b0);
      end else if (v > 64'sh00FFFFFF) begin
        exp_density.push_back(tgi_pkg::TOP_VALUE);
        exp_sat.push_back(1'b1);
      end else begin
        exp_density.push_back(v[tgi_pkg::SAMP_W-1:0]);
        exp_sat.push_back(1'b0);
      end
    endfunction

    function void check(logic [tgi_pkg::SAMP_W-1:0] d, logic s);
      logic [tgi_pkg::SAMP_W-1:0] ed;
      logic es;
      if (exp_density.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: density=%0d sat=%0d", d, s);
        return;
      end
      ed = exp_density.pop_front();
      es = exp_sat.pop_front();
      if (d !== ed || s !== es) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: density exp=%0d got=%0d, saturated exp=%0d got=%0d",
                   ed, d, es, s);
      end
    endfunction

    function int pending();
      return exp_density.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = tgi_pkg::ACT_WRITE;
  logic signed [tgi_pkg::COORD_W-1:0] x_coord = '0, y_coord = '0, eta_coord = '0;
  logic [tgi_pkg::WIDX_W-1:0] write_ix = '0, write_iy = '0, write_ieta = '0;
  logic [tgi_pkg::SAMP_W-1:0] write_value = '0;
  logic done;
  logic [tgi_pkg::SAMP_W-1:0] density;
  logic saturated;
  logic cfg_we = 1'b0;
  logic [tgi_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [tgi_pkg::CFG_W-1:0] cfg_data = '0;

  density_scoreboard sb = new();
  int cycles = 0;
  int fill_idx [7] = '{0, 1, 14, 15, 16, 30, 31};

  trilinear_grid_interpolator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .x_coord(x_coord), .y_coord(y_coord), .eta_coord(eta_coord),
    .write_ix(write_ix), .write_iy(write_iy), .write_ieta(write_ieta),
    .write_value(write_value), .done(done), .density(density),
    .saturated(saturated), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && done) sb.check(density, saturated);
  end

  task automatic send(word_t w);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= w.act;
    x_coord <= w.x;
    y_coord <= w.y;
    eta_coord <= w.e;
    write_ix <= w.wx;
    write_iy <= w.wy;
    write_ieta <= w.we;
    write_value <= w.val;
    do @(posedge clk); while (busy);
    sb.note(w);
  endtask

  // hold until every result is in and the pipeline has emptied
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(tgi_pkg::cfg_idx_t idx, logic [tgi_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic setup(logic [15:0] ox, logic [15:0] oy, logic [15:0] oe,
                       logic [23:0] sx, logic [23:0] sy, logic [23:0] se);
    drain();
    write_reg(tgi_pkg::CFG_X_ORIGIN, {8'd0, ox});
    write_reg(tgi_pkg::CFG_Y_ORIGIN, {8'd0, oy});
    write_reg(tgi_pkg::CFG_ETA_ORIGIN, {8'd0, oe});
    write_reg(tgi_pkg::CFG_X_INV_STEP, sx);
    write_reg(tgi_pkg::CFG_Y_INV_STEP, sy);
    write_reg(tgi_pkg::CFG_ETA_INV_STEP, se);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [tgi_pkg::SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return tgi_pkg::TOP_VALUE;
      default: return tgi_pkg::SAMP_W'($urandom);
    endcase
  endfunction

  // keep a coordinate on a filled cell, else fall back to the origin
  function automatic logic signed [tgi_pkg::COORD_W-1:0] fit(
    logic signed [tgi_pkg::COORD_W-1:0] c, int axis);
    if (sb.cell_ok(c, axis)) return c;
    return sb.org[axis];
  endfunction

  function automatic logic signed [tgi_pkg::COORD_W-1:0] rand_coord(int axis);
    int base;
    int k;
    longint t;
    longint cl;
    logic signed [tgi_pkg::COORD_W-1:0] c;
    for (int n = 0; n < 4; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        c = tgi_pkg::COORD_W'($urandom);
      end else begin
        base = int'(sb.org[axis]) + int'($urandom_range(0, 40 * 256)) - 4 * 256;
        if (base > 32767) base = 32767;
        if (base < -32768) base = -32768;
        c = tgi_pkg::COORD_W'(base);
      end
      if (sb.cell_ok(c, axis)) return c;
    end
    // aim straight at a filled cell
    if (sb.inv[axis] != '0) begin
      case ($urandom_range(0, 3))
        0: k = 0;
        1: k = 14;
        2: k = 15;
        default: k = 30;
      endcase
      t = (longint'(k) <<< 24) + longint'($urandom_range(0, 24'hFFFFFF));
      cl = longint'(sb.org[axis]) + t / longint'({40'd0, sb.inv[axis]});
      if (cl >= -32768 && cl <= 32767) begin
        c = tgi_pkg::COORD_W'(cl);
        if (sb.cell_ok(c, axis)) return c;
      end
    end
    return sb.org[axis];
  endfunction

  function automatic word_t query(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] e);
    word_t w;
    w = '{tgi_pkg::ACT_QUERY, fit(x, 0), fit(y, 1), fit(e, 2),
          tgi_pkg::WIDX_W'($urandom), tgi_pkg::WIDX_W'($urandom),
          tgi_pkg::WIDX_W'($urandom), tgi_pkg::SAMP_W'($urandom)};
    return w;
  endfunction

  task automatic directed();
    send(query(sb.org[0], sb.org[1], sb.org[2]));
    send(query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    send(query(-16'sh8000, -16'sh8000, -16'sh8000));
    send(query(16'sh7FFF, -16'sh8000, 16'sd0));
    send(query(16'sd0, 16'sd0, 16'sd0));
  endtask

  task automatic random_run(int n);
    word_t w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        w = '{tgi_pkg::ACT_WRITE, tgi_pkg::COORD_W'($urandom),
              tgi_pkg::COORD_W'($urandom), tgi_pkg::COORD_W'($urandom),
              tgi_pkg::WIDX_W'($urandom), tgi_pkg::WIDX_W'($urandom),
              tgi_pkg::WIDX_W'($urandom), rand_sample()};
      end else begin
        w = query(rand_coord(0), rand_coord(1), rand_coord(2));
      end
      send(w);
      // let everything in flight come out once in a while
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  initial begin
    word_t w;
    sb.reset_regs();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // fill the corner planes of the cells that queries may touch
    for (int ix = 0; ix < 7; ix++)
      for (int iy = 0; iy < 7; iy++)
        for (int ie = 0; ie < 7; ie++) begin
          w = '{tgi_pkg::ACT_WRITE, tgi_pkg::COORD_W'($urandom),
                tgi_pkg::COORD_W'($urandom), tgi_pkg::COORD_W'($urandom),
                tgi_pkg::WIDX_W'(fill_idx[ix]), tgi_pkg::WIDX_W'(fill_idx[iy]),
                tgi_pkg::WIDX_W'(fill_idx[ie]), rand_sample()};
          send(w);
        end
    directed();
    random_run(300);
    setup(16'h0000, 16'h0000, 16'h0000, 24'd0, 24'd0, 24'd0);
    directed();
    random_run(150);
    setup(16'h8000, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    directed();
    random_run(220);
    setup(16'h7FFF, 16'h8000, 16'h0100, 24'd1, 24'h000200, 24'h020000);
    directed();
    random_run(220);
    for (int k = 0; k < 3; k++) begin
      setup(16'($urandom), 16'($urandom), 16'($urandom),
            24'($urandom_range(0, 24'h040000)), 24'($urandom_range(0, 24'h040000)),
            24'($urandom));
      directed();
      random_run(220);
    end
    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/tgi_pkg.sv
sv/trilinear_grid_interpolator_unit.sv
sv/tgi_checker.sv
sim/tb.sv
